FILE: sv/velocity_vector_accel_limiter_defines.svh
// Assertion macros for the limiter checker file.
`ifndef VELOCITY_VECTOR_ACCEL_LIMITER_DEFINES_SVH
`define VELOCITY_VECTOR_ACCEL_LIMITER_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define VVAL_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define VVAL_ASSERT(lbl, prop, msg) `VVAL_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/vval_pkg.sv
// Package: widths, constants and control types of the velocity limiter.
`timescale 1ns / 1ps
package vval_pkg;

  localparam int unsigned SPEED_WIDTH_DEF = 12;
  localparam int unsigned ROT_WIDTH       = 10;
  localparam int unsigned ACC_WIDTH       = 12;
  localparam logic [ACC_WIDTH-1:0] ACC_RESET = 12'd50;

  // fraction bits of the scaled step, of the length, and the numerator shift
  localparam int unsigned Q_FRAC    = 16;
  localparam int unsigned LEN_FRAC  = 14;
  localparam int unsigned DIV_SHIFT = 30;

  // command to the shared root / divide unit
  typedef struct packed {
    logic start;
    logic div_mode;
  } vval_ctl_t;

endpackage

FILE: sv/vval_if.sv
// Valid/ready channel interfaces for velocity commands and limited results.
`timescale 1ns / 1ps
interface vval_in_if #(
  parameter int unsigned SPEED_WIDTH = vval_pkg::SPEED_WIDTH_DEF
);
  import vval_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] speed_x;
  logic signed [SPEED_WIDTH-1:0] speed_y;
  logic signed [ROT_WIDTH-1:0]   rot_rate;

  modport source (output valid, output speed_x, output speed_y, output rot_rate,
                  input ready);
  modport sink   (input valid, input speed_x, input speed_y, input rot_rate,
                  output ready);
endinterface

interface vval_out_if #(
  parameter int unsigned SPEED_WIDTH = vval_pkg::SPEED_WIDTH_DEF
);
  import vval_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] out_x;
  logic signed [SPEED_WIDTH-1:0] out_y;
  logic signed [ROT_WIDTH-1:0]   out_rot;
  logic                          was_limited;

  modport source (output valid, output out_x, output out_y, output out_rot,
                  output was_limited, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_rot,
                  input was_limited, output ready);
endinterface

FILE: sv/velocity_vector_accel_limiter.sv
// Top level: xy velocity change limiter with shared root / divide unit.
//
//   channel   dir   handshake        beat contents
//   in_i      in    valid / ready    speed_x, speed_y, rot_rate
//   out_o     out   valid / ready    out_x, out_y, out_rot, was_limited
//   max_acc   in    write enable     max_acc_i, taken on max_acc_we_i
//
// A beat whose change stays within max_acc steps through SQX, SQY, ACC and CHK
// to FIN, where its result is loaded into the output register once the output
// is free. A clipped change adds the root and two divisions on the shared unit;
// the shared subtractor produces one root or quotient bit per cycle.
// in_i.ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next beat. Reset clears the last x and y
// to zero and loads max_acc with 50.
`timescale 1ns / 1ps
module velocity_vector_accel_limiter #(
  parameter int unsigned SPEED_WIDTH = vval_pkg::SPEED_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              max_acc_we_i,
  input  logic [vval_pkg::ACC_WIDTH-1:0]    max_acc_i,
  vval_in_if.sink                           in_i,
  vval_out_if.source                        out_o
);
  import vval_pkg::*;

  localparam int unsigned DW   = SPEED_WIDTH + 1;               // difference
  localparam int unsigned D2W  = 2 * SPEED_WIDTH + 2;
  localparam int unsigned MW   = (SPEED_WIDTH > ACC_WIDTH) ? SPEED_WIDTH : ACC_WIDTH;
  localparam int unsigned PRW  = 2 * MW;
  localparam int unsigned CMPW = (PRW > D2W) ? PRW : D2W;
  localparam int unsigned PW   = ACC_WIDTH + SPEED_WIDTH;
  localparam int unsigned QW   = ACC_WIDTH + Q_FRAC + 1;
  localparam int unsigned STW  = QW - Q_FRAC + 1;               // step bits
  localparam int unsigned EW   = ((SPEED_WIDTH > STW) ? SPEED_WIDTH : STW) + 2;
  localparam logic signed [EW-1:0] SAT_HI = EW'((1 << (SPEED_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
  localparam logic [QW:0] ROUND_UP = (QW+1)'((1 << Q_FRAC) - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ACC, ST_CHK, ST_SQRT,
    ST_MULX, ST_DIVX, ST_MULY, ST_DIVY, ST_FIN
  } state_e;

  state_e                        state_q;
  logic                          start_q;
  logic                          div_q;
  logic [ACC_WIDTH-1:0]          max_acc_q;
  logic signed [SPEED_WIDTH-1:0] prev_x_q;
  logic signed [SPEED_WIDTH-1:0] prev_y_q;
  logic signed [SPEED_WIDTH-1:0] sx_q;
  logic signed [SPEED_WIDTH-1:0] sy_q;
  logic signed [ROT_WIDTH-1:0]   rot_q;
  logic signed [DW-1:0]          dx_q;
  logic signed [DW-1:0]          dy_q;
  logic [PRW-1:0]                prod_q;
  logic [D2W-1:0]                d2_q;
  logic                          lim_q;
  logic signed [EW-1:0]          nx_q;
  logic signed [EW-1:0]          ny_q;
  logic                          out_valid_q;
  logic signed [SPEED_WIDTH-1:0] out_x_q;
  logic signed [SPEED_WIDTH-1:0] out_y_q;
  logic signed [ROT_WIDTH-1:0]   out_rot_q;
  logic                          out_lim_q;

  logic [DW-1:0]          absx;
  logic [DW-1:0]          absy;
  logic [SPEED_WIDTH-1:0] magx;
  logic [SPEED_WIDTH-1:0] magy;
  logic [MW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic [PRW-1:0]         prod;
  logic                   over_lim;
  logic                   out_free;
  vval_ctl_t              sqd_ctl;
  logic                   sqd_done;
  logic [QW-1:0]          sqd_quo;

  // prev plus the ceiling of a positive step, or minus the floor of a negative one
  function automatic logic signed [EW-1:0] apply_step(
    input logic signed [SPEED_WIDTH-1:0] prev,
    input logic                          neg,
    input logic [QW-1:0]                 q
  );
    logic [QW:0]   q_up;
    logic [EW-1:0] step;
    q_up = (QW+1)'(q) + ROUND_UP;
    if (neg) begin
      step = EW'(q[QW-1:Q_FRAC]);
      return EW'(prev) - step;
    end else begin
      step = EW'(q_up[QW:Q_FRAC]);
      return EW'(prev) + step;
    end
  endfunction

  function automatic logic signed [SPEED_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[SPEED_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[SPEED_WIDTH-1:0];
    end
    return v[SPEED_WIDTH-1:0];
  endfunction

  // component magnitudes
  assign absx = dx_q[DW-1] ? -dx_q : dx_q;
  assign absy = dy_q[DW-1] ? -dy_q : dy_q;
  assign magx = absx[SPEED_WIDTH-1:0];
  assign magy = absy[SPEED_WIDTH-1:0];

  // the one multiplier, operands picked by state
  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = MW'(magx);
        mul_b = MW'(magx);
      end
      ST_SQY: begin
        mul_a = MW'(magy);
        mul_b = MW'(magy);
      end
      ST_MULX: begin
        mul_a = MW'(max_acc_q);
        mul_b = MW'(magx);
      end
      ST_MULY: begin
        mul_a = MW'(max_acc_q);
        mul_b = MW'(magy);
      end
      default: begin
        mul_a = MW'(max_acc_q);
        mul_b = MW'(max_acc_q);
      end
    endcase
    prod = mul_a * mul_b;
  end

  // squared change against squared limit
  assign over_lim = CMPW'(d2_q) > CMPW'(prod_q);

  assign out_free = !out_valid_q || out_o.ready;
  assign sqd_ctl  = '{start: start_q, div_mode: div_q};

  vval_sqdiv #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sqd_ctl),
    .d2_i   (d2_q),
    .num_i  (prod_q[PW-1:0]),
    .done_o (sqd_done),
    .quo_o  (sqd_quo)
  );

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      div_q       <= 1'b0;
      max_acc_q   <= ACC_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // kick the shared unit for the root and both divisions
      start_q <= (state_q == ST_CHK && over_lim) || (state_q == ST_MULX) ||
                 (state_q == ST_MULY);
      // result offered until taken, reloaded when the sequencer finishes
      out_valid_q <= (state_q == ST_FIN && out_free) || (out_valid_q && !out_o.ready);
      if (max_acc_we_i) begin
        max_acc_q <= max_acc_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            sx_q    <= in_i.speed_x;
            sy_q    <= in_i.speed_y;
            rot_q   <= in_i.rot_rate;
            dx_q    <= DW'(in_i.speed_x) - DW'(prev_x_q);
            dy_q    <= DW'(in_i.speed_y) - DW'(prev_y_q);
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          prod_q  <= prod;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          d2_q    <= D2W'(prod_q) + D2W'(prod);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          prod_q  <= prod;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          lim_q <= over_lim;
          if (over_lim) begin
            div_q   <= 1'b0;
            state_q <= ST_SQRT;
          end else begin
            nx_q    <= EW'(sx_q);
            ny_q    <= EW'(sy_q);
            state_q <= ST_FIN;
          end
        end
        ST_SQRT: begin
          if (sqd_done) begin
            state_q <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod_q  <= prod;
          div_q   <= 1'b1;
          state_q <= ST_DIVX;
        end
        ST_DIVX: begin
          if (sqd_done) begin
            nx_q    <= apply_step(prev_x_q, dx_q[DW-1], sqd_quo);
            state_q <= ST_MULY;
          end
        end
        ST_MULY: begin
          prod_q  <= prod;
          div_q   <= 1'b1;
          state_q <= ST_DIVY;
        end
        ST_DIVY: begin
          if (sqd_done) begin
            ny_q    <= apply_step(prev_y_q, dy_q[DW-1], sqd_quo);
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            prev_x_q    <= sat(nx_q);
            prev_y_q    <= sat(ny_q);
            out_x_q     <= sat(nx_q);
            out_y_q     <= sat(ny_q);
            out_rot_q   <= rot_q;
            out_lim_q   <= lim_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.out_y       = out_y_q;
  assign out_o.out_rot     = out_rot_q;
  assign out_o.was_limited = out_lim_q;

endmodule

FILE: sv/vval_sqdiv.sv
// Shared bit-serial square root and divider built around one subtractor.
`timescale 1ns / 1ps
module vval_sqdiv #(
  parameter int unsigned SPEED_WIDTH = vval_pkg::SPEED_WIDTH_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  vval_pkg::vval_ctl_t                               ctl_i,
  input  logic [2*SPEED_WIDTH+1:0]                          d2_i,
  input  logic [vval_pkg::ACC_WIDTH+SPEED_WIDTH-1:0]        num_i,
  output logic                                              done_o,
  output logic [vval_pkg::ACC_WIDTH+vval_pkg::Q_FRAC:0]     quo_o
);
  import vval_pkg::*;

  localparam int unsigned D2W  = 2 * SPEED_WIDTH + 2;
  localparam int unsigned RW   = SPEED_WIDTH + LEN_FRAC + 1;   // root bits
  localparam int unsigned SW   = RW + 2;                       // subtractor width
  localparam int unsigned QW   = ACC_WIDTH + Q_FRAC + 1;       // quotient bits
  localparam int unsigned PSH  = DIV_SHIFT - QW;               // preshift of numerator
  localparam int unsigned ITER_MAX = (RW > QW) ? RW : QW;
  localparam int unsigned CNTW = $clog2(ITER_MAX + 1);

  logic            busy_q;
  logic            done_q;
  logic            mode_q;      // 1: divide, 0: square root
  logic [CNTW-1:0] cnt_q;
  logic [SW-1:0]   rem_q;
  logic [SW-1:0]   rem_d;
  logic [RW-1:0]   root_q;      // length in Q14, held as divisor
  logic [D2W-1:0]  sh_q;        // radicand bits, two per step
  logic [QW-1:0]   quo_q;

  logic [SW-1:0]   opa;
  logic [SW-1:0]   opb;
  logic [SW:0]     diff;
  logic            ge;

  // the one shared subtract / compare
  always_comb begin
    if (mode_q) begin
      opa = {rem_q[SW-2:0], 1'b0};
      opb = SW'(root_q);
    end else begin
      opa = {rem_q[RW-1:0], sh_q[D2W-1 -: 2]};
      opb = {root_q, 2'b01};
    end
    diff  = {1'b0, opa} - {1'b0, opb};
    ge    = ~diff[SW];
    rem_d = ge ? diff[SW-1:0] : opa;
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !ctl_i.start && busy_q && (cnt_q == CNTW'(1));
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        mode_q <= ctl_i.div_mode;
        cnt_q  <= ctl_i.div_mode ? CNTW'(QW) : CNTW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath: one root or quotient bit per step
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      if (ctl_i.div_mode) begin
        rem_q <= SW'(num_i) << PSH;
        quo_q <= '0;
      end else begin
        rem_q  <= '0;
        root_q <= '0;
        sh_q   <= d2_i;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      if (mode_q) begin
        quo_q <= {quo_q[QW-2:0], ge};
      end else begin
        root_q <= {root_q[RW-2:0], ge};
        sh_q   <= sh_q << 2;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/vval_checker.sv
// Port-level checker for the velocity limiter, bound to the top level.
`timescale 1ns / 1ps
`include "velocity_vector_accel_limiter_defines.svh"
module vval_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_q;   // beats taken whose result is not yet delivered

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // track outstanding beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // a stalled result stays offered
  `VVAL_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  // the sequencer is busy right after taking a beat
  `VVAL_ASSERT(a_busy_after_take, in_beat |=> !in_ready_i, "ready right after a taken beat")
  // no result without a beat behind it
  `VVAL_ASSERT(a_no_invented, out_valid_i |-> pend_q != 2'd0, "result with no beat outstanding")
  // at most one beat at work and one result waiting
  `VVAL_ASSERT(a_pend_bound, pend_q != 2'd3, "too many beats outstanding")

endmodule

bind velocity_vector_accel_limiter vval_checker u_vval_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
